FILE: rtl/omwo_pkg.sv
// Shared types, constants and helpers for the omni-wheel odometry integrator.
// Used by omwo_cordic, omwo_mac and omni_wheel_odometry_integrator; no dependencies.
package omwo_pkg;

  // Datapath widths
  localparam int unsigned XY_W       = 34;            // CORDIC x/y/z, Q2.30 with headroom
  localparam int unsigned OPB_W      = 32;            // second multiplier operand
  localparam int unsigned ACC_W      = XY_W + OPB_W;  // full product and accumulator
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned CFG_W      = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ATAN_N     = 24;
  localparam int unsigned ATAN_IDX_W = 5;

  // Default iteration count of the sine/cosine unit
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW2 = 2'd2;

  // Converged CORDIC gain in Q2.30 and radians-to-binary-angle scale in Q16
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [OPB_W-1:0] RAD_TO_BAM_Q16  = 32'sd683565276;

  // Arctangent of 2^-i as a 32-bit binary angle
  localparam logic [31:0] ATAN_BAM32 [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Input beat
  typedef struct packed {
    logic signed [15:0] wheel_speed_a;
    logic signed [15:0] wheel_speed_b;
    logic signed [15:0] wheel_speed_c;
    logic        [15:0] step_time;
  } omwo_in_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [15:0] pose_heading;
    logic signed [15:0] local_vx;
    logic signed [15:0] local_vy;
    logic signed [15:0] local_wz;
    logic signed [15:0] world_vx;
    logic signed [15:0] world_vy;
  } omwo_out_t;

  // Sine/cosine unit result: raw x (cosine) and y (sine), and the half-turn fold
  typedef struct packed {
    logic                   flip;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } omwo_trig_t;

  // Multiply-accumulate control for one issued product
  typedef struct packed {
    logic issue;
    logic clr;
    logic neg;
  } omwo_mac_ctl_t;

  // Saturate an accumulator value to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7FFF;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Saturate a 34-bit sum to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/omwo_cordic.sv
// Iterative rotation-mode CORDIC: one shift-add micro-rotation per cycle.
// Depends on omwo_pkg (widths, gain, arctangent table, result struct).
module omwo_cordic #(
  parameter int unsigned CORDIC_STEPS = omwo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [15:0]         angle_i,
  output omwo_pkg::omwo_trig_t res_o
);
  import omwo_pkg::*;

  localparam int unsigned ITER_W = $clog2(CORDIC_STEPS + 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS);

  logic [ITER_W-1:0]      iter_q;
  logic signed [XY_W-1:0] x_q, y_q, z_q;
  logic                   flip_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [XY_W-1:0] atan_ext;
  logic [31:0]            z32;
  logic                   fold;

  // Fold the angle into the right half plane
  assign fold = angle_i[15] ^ angle_i[14];
  assign z32  = {angle_i[15] ^ fold, angle_i[14:0], 16'h0000};

  // Shift unit and arctangent lookup for this iteration
  assign dx       = y_q >>> iter_q;
  assign dy       = x_q >>> iter_q;
  assign atan_ext = XY_W'(ATAN_BAM32[ATAN_IDX_W'(iter_q)]);

  // Count iterations; idle at the last count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= ITER_LAST;
    end else if (start_i) begin
      iter_q <= '0;
    end else if (iter_q != ITER_LAST) begin
      iter_q <= iter_q + 1'b1;
    end
  end

  // Load, then rotate towards zero residual angle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN_Q30;
      y_q    <= '0;
      z_q    <= XY_W'(signed'(z32));
      flip_q <= fold;
    end else if (iter_q != ITER_LAST) begin
      if (!z_q[XY_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_ext;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_ext;
      end
    end
  end

  assign res_o.flip = flip_q;
  assign res_o.x    = x_q;
  assign res_o.y    = y_q;

endmodule

FILE: rtl/omwo_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate or clear.
// Depends on omwo_pkg (widths, control struct).
module omwo_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  omwo_pkg::omwo_mac_ctl_t            ctl_i,
  input  logic signed [omwo_pkg::XY_W-1:0]   op_a_i,
  input  logic signed [omwo_pkg::OPB_W-1:0]  op_b_i,
  output logic signed [omwo_pkg::ACC_W-1:0]  acc_o
);
  import omwo_pkg::*;

  omwo_mac_ctl_t           ctl_q;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, base;

  // Hold control alongside the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // Register the product
  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      prod_q <= ACC_W'(op_a_i) * ACC_W'(op_b_i);
    end
  end

  // Add or subtract the product into the accumulator
  always_comb begin
    base  = ctl_q.clr ? '0 : acc_q;
    acc_d = ctl_q.neg ? base - prod_q : base + prod_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q.issue) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/omni_wheel_odometry_integrator.sv
// Omni-wheel dead-reckoning odometry: top level with sequencer and pose state.
// Depends on omwo_pkg, omwo_cordic and omwo_mac.
//
// Usage: write the three inverse-kinematics rows on the cfg port while idle
// (cfg_we_i, cfg_idx_i, cfg_data_i; index three is ignored). Each input beat
// carries three wheel speeds and a step time; each one yields exactly one
// result beat with the updated pose, body velocity and world velocity.
// How long one beat occupies the block, from acceptance to the result
// register, is set by the single shared multiplier, which takes all
// seventeen products in turn, and by the CORDIC unit, which runs one
// micro-rotation a cycle alongside the matrix products. in_ready_o is low
// while an item is being worked on. The result sits in an output register;
// the next item may be accepted while it waits, and a new result holds at
// its final step until the previous one has been taken. Reset clears the
// pose, the heading, the matrix rows and both handshakes.
module omni_wheel_odometry_integrator #(
  parameter int unsigned CORDIC_STEPS = omwo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [omwo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [omwo_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  omwo_pkg::omwo_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output omwo_pkg::omwo_out_t               out_data_o
);
  import omwo_pkg::*;

  // Schedule of the sequencer
  localparam int unsigned ROT_I  = (CORDIC_STEPS > 16) ? CORDIC_STEPS : 16;
  localparam int unsigned LAST_I = ROT_I + 9;
  localparam int unsigned STEP_W = $clog2(LAST_I + 1);

  localparam logic [STEP_W-1:0] S_R0A   = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_R0B   = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_R0C   = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_R1A   = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_R1B   = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_R1C   = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_R2A   = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_R2B   = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_R2C   = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_WZ    = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_WZDT  = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_SCALE = STEP_W'(13);
  localparam logic [STEP_W-1:0] S_HEAD  = STEP_W'(15);
  localparam logic [STEP_W-1:0] S_ROT0  = STEP_W'(ROT_I);
  localparam logic [STEP_W-1:0] S_ROT1  = STEP_W'(ROT_I + 1);
  localparam logic [STEP_W-1:0] S_ROT2  = STEP_W'(ROT_I + 2);
  localparam logic [STEP_W-1:0] S_ROT3  = STEP_W'(ROT_I + 3);
  localparam logic [STEP_W-1:0] S_GXDT  = STEP_W'(ROT_I + 4);
  localparam logic [STEP_W-1:0] S_GY    = STEP_W'(ROT_I + 5);
  localparam logic [STEP_W-1:0] S_GYDT  = STEP_W'(ROT_I + 6);
  localparam logic [STEP_W-1:0] S_PY    = STEP_W'(ROT_I + 8);
  localparam logic [STEP_W-1:0] S_LAST  = STEP_W'(LAST_I);
  // Captures that share a step with a product issue
  localparam logic [STEP_W-1:0] S_VX    = S_R1B;
  localparam logic [STEP_W-1:0] S_VY    = S_R2B;
  localparam logic [STEP_W-1:0] S_GX    = S_ROT3;
  localparam logic [STEP_W-1:0] S_PX    = S_GYDT;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    in_fire, out_fire, out_load;

  logic [CFG_W-1:0]        row0_q, row1_q, row2_q;
  omwo_in_t                in_q;
  logic signed [31:0]      pos_x_q, pos_y_q;
  logic [15:0]             heading_q;
  logic signed [15:0]      vx_q, vy_q, wz_q, gx_q, gy_q;
  logic                    out_valid_q;
  omwo_out_t               out_q;

  omwo_trig_t              trig;
  omwo_mac_ctl_t           mac_ctl;
  logic signed [XY_W-1:0]  op_a;
  logic signed [OPB_W-1:0] op_b;
  logic signed [ACC_W-1:0] acc;

  logic signed [ACC_W-1:0] rnd12, rnd30, rnd8;
  logic signed [OPB_W-1:0] dt_op;
  logic [15:0]             head_delta;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_load    = (state_q == ST_RUN) && (step_q == S_LAST) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= '0;
      row1_q <= '0;
      row2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INV_ROW0: row0_q <= cfg_data_i;
        REG_INV_ROW1: row1_q <= cfg_data_i;
        REG_INV_ROW2: row2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the sequencer; hold at the final step while the result register is full and not being taken
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (step_q == S_LAST) begin
          if (out_load) begin
            state_d = ST_IDLE;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Latch the input beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
  end

  // Sine and cosine of the heading held before this update
  omwo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .angle_i (heading_q),
    .res_o   (trig)
  );

  // Select multiplier operands for each step
  assign dt_op = OPB_W'({1'b0, in_q.step_time});

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    mac_ctl = '0;
    if (state_q == ST_RUN) begin
      unique case (step_q)
        S_R0A: begin
          op_a = XY_W'(in_q.wheel_speed_a); op_b = OPB_W'(signed'(row0_q[15:0]));
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
        end
        S_R0B: begin
          op_a = XY_W'(in_q.wheel_speed_b); op_b = OPB_W'(signed'(row0_q[31:16]));
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: 1'b0};
        end
        S_R0C: begin
          op_a = XY_W'(in_q.wheel_speed_c); op_b = OPB_W'(signed'(row0_q[47:32]));
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: 1'b0};
        end
        S_R1A: begin
          op_a = XY_W'(in_q.wheel_speed_a); op_b = OPB_W'(signed'(row1_q[15:0]));
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
        end
        S_R1B: begin
          op_a = XY_W'(in_q.wheel_speed_b); op_b = OPB_W'(signed'(row1_q[31:16]));
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: 1'b0};
        end
        S_R1C: begin
          op_a = XY_W'(in_q.wheel_speed_c); op_b = OPB_W'(signed'(row1_q[47:32]));
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: 1'b0};
        end
        S_R2A: begin
          op_a = XY_W'(in_q.wheel_speed_a); op_b = OPB_W'(signed'(row2_q[15:0]));
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
        end
        S_R2B: begin
          op_a = XY_W'(in_q.wheel_speed_b); op_b = OPB_W'(signed'(row2_q[31:16]));
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: 1'b0};
        end
        S_R2C: begin
          op_a = XY_W'(in_q.wheel_speed_c); op_b = OPB_W'(signed'(row2_q[47:32]));
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: 1'b0};
        end
        S_WZDT: begin
          op_a = XY_W'(wz_q); op_b = dt_op;
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
        end
        S_SCALE: begin
          op_a = acc[XY_W-1:0]; op_b = RAD_TO_BAM_Q16;
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
        end
        // Rotation: a folded heading negates both cosine and sine
        S_ROT0: begin
          op_a = trig.x; op_b = OPB_W'(vx_q);
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: trig.flip};
        end
        S_ROT1: begin
          op_a = trig.y; op_b = OPB_W'(vy_q);
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: !trig.flip};
        end
        S_ROT2: begin
          op_a = trig.y; op_b = OPB_W'(vx_q);
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: trig.flip};
        end
        S_ROT3: begin
          op_a = trig.x; op_b = OPB_W'(vy_q);
          mac_ctl = '{issue: 1'b1, clr: 1'b0, neg: trig.flip};
        end
        S_GXDT: begin
          op_a = XY_W'(gx_q); op_b = dt_op;
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
        end
        S_GYDT: begin
          op_a = XY_W'(gy_q); op_b = dt_op;
          mac_ctl = '{issue: 1'b1, clr: 1'b1, neg: 1'b0};
        end
        default: ;
      endcase
    end
  end

  omwo_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  // Round half up at the four result scalings
  assign rnd12      = (acc + (ACC_W'(1) <<< 11)) >>> 12;
  assign rnd30      = (acc + (ACC_W'(1) <<< 29)) >>> 30;
  assign rnd8       = (acc + (ACC_W'(1) <<< 7)) >>> 8;
  assign head_delta = acc[55:40] + {15'd0, acc[39]};

  // Capture velocities from the accumulator
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      case (step_q)
        S_VX: vx_q <= sat16(rnd12);
        S_VY: vy_q <= sat16(rnd12);
        S_WZ: wz_q <= sat16(rnd12);
        S_GX: gx_q <= sat16(rnd30);
        S_GY: gy_q <= sat16(rnd30);
        default: ;
      endcase
    end
  end

  // Integrate pose and heading
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      heading_q <= '0;
    end else if (state_q == ST_RUN) begin
      case (step_q)
        S_HEAD: heading_q <= heading_q + head_delta;
        S_PX:   pos_x_q   <= sat32(34'(pos_x_q) + rnd8[33:0]);
        S_PY:   pos_y_q   <= sat32(34'(pos_y_q) + rnd8[33:0]);
        default: ;
      endcase
    end
  end

  // Result register: load at the final step, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pose_x       <= pos_x_q;
      out_q.pose_y       <= pos_y_q;
      out_q.pose_heading <= heading_q;
      out_q.local_vx     <= vx_q;
      out_q.local_vy     <= vy_q;
      out_q.local_wz     <= wz_q;
      out_q.world_vx     <= gx_q;
      out_q.world_vy     <= gy_q;
    end
  end

endmodule
